[src/psd_pkg.sv]
// Pressure step detector package: shared types, register indexes, phase codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int LEVEL_W      = 20;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 20;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = 2;
    localparam int CREDIT_W     = QUEUE_AW + 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_WALK_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_THRESHOLD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HANG_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTH_FACTOR  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WALK_DWELL     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_DWELL      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_LIMIT  = 3'd6;

    localparam logic [7:0] SMOOTH_FACTOR_RESET = 8'd128;
    localparam logic [7:0] WALK_DWELL_RESET    = 8'd20;
    localparam logic [7:0] RUN_DWELL_RESET     = 8'd10;
    localparam logic [7:0] TIMEOUT_LIMIT_RESET = 8'd200;

    localparam logic [2:0] PHASE_CODE_IDLE      = 3'd0;
    localparam logic [2:0] PHASE_CODE_WALK_DIP  = 3'd1;
    localparam logic [2:0] PHASE_CODE_RUN_DIP   = 3'd2;
    localparam logic [2:0] PHASE_CODE_WALK_HELD = 3'd3;
    localparam logic [2:0] PHASE_CODE_RUN_HELD  = 3'd4;
    localparam logic [2:0] PHASE_CODE_WALK_DONE = 3'd5;
    localparam logic [2:0] PHASE_CODE_RUN_DONE  = 3'd6;

    localparam logic [1:0] EVENT_NONE = 2'd0;
    localparam logic [1:0] EVENT_WALK = 2'd1;
    localparam logic [1:0] EVENT_RUN  = 2'd2;

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_WALK_DIP  = 7'b0000010,
        PH_RUN_DIP   = 7'b0000100,
        PH_WALK_HELD = 7'b0001000,
        PH_RUN_HELD  = 7'b0010000,
        PH_WALK_DONE = 7'b0100000,
        PH_RUN_DONE  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] walk_threshold;
        logic [LEVEL_W-1:0] run_threshold;
        logic [LEVEL_W-1:0] hang_threshold;
        logic [7:0]         smooth_factor;
        logic [7:0]         walk_dwell;
        logic [7:0]         run_dwell;
        logic [7:0]         timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] mean;
        logic               counting_enabled;
    } queue_word_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:      code = PHASE_CODE_IDLE;
            PH_WALK_DIP:  code = PHASE_CODE_WALK_DIP;
            PH_RUN_DIP:   code = PHASE_CODE_RUN_DIP;
            PH_WALK_HELD: code = PHASE_CODE_WALK_HELD;
            PH_RUN_HELD:  code = PHASE_CODE_RUN_HELD;
            PH_WALK_DONE: code = PHASE_CODE_WALK_DONE;
            PH_RUN_DONE:  code = PHASE_CODE_RUN_DONE;
            default:      code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[src/psd_front.sv]
// Front end: sums the samples of a word and scales the sum to a rounded Q12.8 mean.
// Two register stages, no stall; uses psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_front #(
    parameter int SAMPLES_PER_TICK = 5
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic [psd_pkg::SAMPLE_W-1:0]  sample_a,
    input  wire logic [psd_pkg::SAMPLE_W-1:0]  sample_b,
    input  wire logic [psd_pkg::SAMPLE_W-1:0]  sample_c,
    input  wire logic [psd_pkg::SAMPLE_W-1:0]  sample_d,
    input  wire logic [psd_pkg::SAMPLE_W-1:0]  sample_e,
    input  wire logic                          counting_enabled,
    output logic                               out_valid,
    output psd_pkg::queue_word_t               out_word
);

    localparam int NUSED = (SAMPLES_PER_TICK > 5) ? 5 :
                           ((SAMPLES_PER_TICK < 1) ? 1 : SAMPLES_PER_TICK);
    localparam int SUM_W       = psd_pkg::SAMPLE_W + 3;
    localparam int X_W         = SUM_W + 8;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** RECIP_SHIFT) + NUSED - 1) / NUSED);
    localparam logic [X_W-1:0] ROUND_HALF = X_W'(NUSED / 2);

    logic [psd_pkg::SAMPLE_W-1:0] samples [5];
    logic [SUM_W-1:0]             sum;
    logic [X_W-1:0]               x_next;
    logic [PROD_W-1:0]            prod;

    logic                         v1_reg;
    logic                         en1_reg;
    logic [X_W-1:0]               x1_reg;
    logic                         v2_reg;
    psd_pkg::queue_word_t         word2_reg;

    assign samples[0] = sample_a;
    assign samples[1] = sample_b;
    assign samples[2] = sample_c;
    assign samples[3] = sample_d;
    assign samples[4] = sample_e;

    always_comb begin
        sum = '0;
        for (int i = 0; i < NUSED; i++) begin
            sum = sum + SUM_W'(samples[i]);
        end
    end

    assign x_next = {sum, 8'd0} + ROUND_HALF;
    assign prod   = PROD_W'(x1_reg) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        en1_reg                    <= counting_enabled;
        x1_reg                     <= x_next;
        word2_reg.mean             <= prod[RECIP_SHIFT + psd_pkg::LEVEL_W - 1:RECIP_SHIFT];
        word2_reg.counting_enabled <= en1_reg;
    end

    assign out_valid = v2_reg;
    assign out_word  = word2_reg;

endmodule

`default_nettype wire

[src/psd_queue.sv]
// Four-word queue between the front end and the step engine.
// Register array with read and write pointers; uses psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire psd_pkg::queue_word_t  push_word,
    input  wire logic                  pop,
    output logic                       out_valid,
    output psd_pkg::queue_word_t       out_word
);

    psd_pkg::queue_word_t              mem [psd_pkg::QUEUE_DEPTH];
    logic [psd_pkg::QUEUE_AW-1:0]      wr_ptr_reg;
    logic [psd_pkg::QUEUE_AW-1:0]      rd_ptr_reg;
    logic [psd_pkg::CREDIT_W-1:0]      count_reg;
    logic [psd_pkg::CREDIT_W-1:0]      count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_word  = mem[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && !pop && (count_reg == psd_pkg::CREDIT_W'(psd_pkg::QUEUE_DEPTH))))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");

endmodule

`default_nettype wire

[src/psd_back.sv]
// Step engine: exponential filter, phase machine, step totals and result register.
// Pops words from psd_queue; uses psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire psd_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    input  wire psd_pkg::queue_word_t          in_word,
    output logic                               pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [psd_pkg::LEVEL_W-1:0]        m_filtered_pressure,
    output logic [2:0]                         m_phase,
    output logic                               m_walk_led,
    output logic                               m_run_led,
    output logic [31:0]                        m_walk_steps,
    output logic [31:0]                        m_run_steps,
    output logic [1:0]                         m_step_event,
    output logic                               m_timed_out
);

    localparam int W = psd_pkg::LEVEL_W;

    logic [W-1:0]          level_reg;
    logic [W-1:0]          level_next;
    psd_pkg::phase_t       phase_reg;
    psd_pkg::phase_t       phase_next;
    logic [7:0]            dwell_reg;
    logic [7:0]            dwell_next;
    logic [7:0]            dwell_up;
    logic [7:0]            busy_reg;
    logic [7:0]            busy_next;
    logic [31:0]           walk_total_reg;
    logic [31:0]           walk_total_next;
    logic [31:0]           run_total_reg;
    logic [31:0]           run_total_next;
    logic                  walk_lamp_reg;
    logic                  walk_lamp_next;
    logic                  run_lamp_reg;
    logic                  run_lamp_next;
    logic [1:0]            event_next;
    logic                  tout_next;
    logic                  walk_zone;
    logic                  run_zone;
    logic                  lifted;

    logic signed [W:0]     diff;
    logic signed [8:0]     factor;
    logic signed [W+9:0]   weighted;
    logic signed [W+9:0]   shifted;

    logic                  m_valid_reg;
    logic [W-1:0]          m_level_reg;
    logic [2:0]            m_phase_reg;
    logic                  m_walk_led_reg;
    logic                  m_run_led_reg;
    logic [31:0]           m_walk_steps_reg;
    logic [31:0]           m_run_steps_reg;
    logic [1:0]            m_event_reg;
    logic                  m_tout_reg;

    assign pop = in_valid && (!m_valid_reg || m_ready);

    // mean + f * (old - mean) / 256, rounded half up
    assign diff       = $signed({1'b0, level_reg}) - $signed({1'b0, in_word.mean});
    assign factor     = $signed({1'b0, cfg.smooth_factor});
    assign weighted   = (W+10)'(diff * factor) + (W+10)'(128);
    assign shifted    = weighted >>> 8;
    assign level_next = in_word.mean + shifted[W-1:0];

    assign walk_zone = (level_next < cfg.walk_threshold) && (level_next >= cfg.run_threshold);
    assign run_zone  = level_next < cfg.run_threshold;
    assign lifted    = level_next > cfg.hang_threshold;

    always_comb begin
        phase_next      = phase_reg;
        dwell_next      = dwell_reg;
        busy_next       = busy_reg;
        walk_total_next = walk_total_reg;
        run_total_next  = run_total_reg;
        walk_lamp_next  = walk_lamp_reg;
        run_lamp_next   = run_lamp_reg;
        event_next      = psd_pkg::EVENT_NONE;
        tout_next       = 1'b0;
        dwell_up        = dwell_reg;
        if (in_word.counting_enabled) begin
            if (phase_reg != psd_pkg::PH_IDLE) begin
                if (busy_reg != 8'hFF) begin
                    busy_next = busy_reg + 8'd1;
                end
            end else begin
                busy_next = '0;
            end
            if (busy_next > cfg.timeout_limit) begin
                walk_lamp_next = 1'b0;
                run_lamp_next  = 1'b0;
                phase_next     = psd_pkg::PH_IDLE;
                busy_next      = '0;
                dwell_next     = '0;
                tout_next      = 1'b1;
            end
            dwell_up = (dwell_next != 8'hFF) ? dwell_next + 8'd1 : dwell_next;
            case (phase_next)
                psd_pkg::PH_IDLE: begin
                    if (walk_zone) begin
                        phase_next = psd_pkg::PH_WALK_DIP;
                    end else if (run_zone) begin
                        phase_next = psd_pkg::PH_RUN_DIP;
                    end
                end
                psd_pkg::PH_WALK_DIP: begin
                    if (walk_zone) begin
                        dwell_next = dwell_up;
                        if (dwell_up >= cfg.walk_dwell) begin
                            walk_lamp_next = 1'b1;
                            dwell_next     = '0;
                            phase_next     = psd_pkg::PH_WALK_HELD;
                        end
                    end else if (run_zone) begin
                        walk_lamp_next = 1'b0;
                        dwell_next     = dwell_next >> 1;
                        phase_next     = psd_pkg::PH_RUN_DIP;
                    end
                end
                psd_pkg::PH_RUN_DIP: begin
                    if (run_zone) begin
                        dwell_next = dwell_up;
                        if (dwell_up >= cfg.run_dwell) begin
                            run_lamp_next = 1'b1;
                            dwell_next    = '0;
                            phase_next    = psd_pkg::PH_RUN_HELD;
                        end
                    end
                end
                psd_pkg::PH_WALK_HELD: begin
                    if (lifted) begin
                        dwell_next = dwell_up;
                        if (dwell_up >= cfg.walk_dwell) begin
                            dwell_next = '0;
                            phase_next = psd_pkg::PH_WALK_DONE;
                        end
                    end
                end
                psd_pkg::PH_RUN_HELD: begin
                    if (lifted) begin
                        dwell_next = dwell_up;
                        if (dwell_up >= cfg.run_dwell) begin
                            dwell_next = '0;
                            phase_next = psd_pkg::PH_RUN_DONE;
                        end
                    end
                end
                psd_pkg::PH_WALK_DONE: begin
                    phase_next      = psd_pkg::PH_IDLE;
                    walk_total_next = walk_total_reg + 32'd1;
                    walk_lamp_next  = 1'b0;
                    event_next      = psd_pkg::EVENT_WALK;
                end
                psd_pkg::PH_RUN_DONE: begin
                    phase_next     = psd_pkg::PH_IDLE;
                    run_total_next = run_total_reg + 32'd1;
                    run_lamp_next  = 1'b0;
                    event_next     = psd_pkg::EVENT_RUN;
                end
                default: begin
                    phase_next = psd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg      <= '0;
            phase_reg      <= psd_pkg::PH_IDLE;
            dwell_reg      <= '0;
            busy_reg       <= '0;
            walk_total_reg <= '0;
            run_total_reg  <= '0;
            walk_lamp_reg  <= 1'b0;
            run_lamp_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (pop) begin
                level_reg      <= level_next;
                phase_reg      <= phase_next;
                dwell_reg      <= dwell_next;
                busy_reg       <= busy_next;
                walk_total_reg <= walk_total_next;
                run_total_reg  <= run_total_next;
                walk_lamp_reg  <= walk_lamp_next;
                run_lamp_reg   <= run_lamp_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_level_reg      <= level_next;
            m_phase_reg      <= psd_pkg::phase_code(phase_next);
            m_walk_led_reg   <= walk_lamp_next;
            m_run_led_reg    <= run_lamp_next;
            m_walk_steps_reg <= walk_total_next;
            m_run_steps_reg  <= run_total_next;
            m_event_reg      <= event_next;
            m_tout_reg       <= tout_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_filtered_pressure = m_level_reg;
    assign m_phase             = m_phase_reg;
    assign m_walk_led          = m_walk_led_reg;
    assign m_run_led           = m_run_led_reg;
    assign m_walk_steps        = m_walk_steps_reg;
    assign m_run_steps         = m_run_steps_reg;
    assign m_step_event        = m_event_reg;
    assign m_timed_out         = m_tout_reg;

    a_timeout_lamps_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tout_reg) |-> (!m_walk_led_reg && !m_run_led_reg))
        else $error("lamp lit on a timed-out word");

    a_event_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_event_reg != psd_pkg::EVENT_NONE))
            |-> (m_phase_reg == psd_pkg::PHASE_CODE_IDLE))
        else $error("step counted without return to idle");

endmodule

`default_nettype wire

[src/pressure_step_detector.sv]
// Pressure step detector top level: configuration registers, credit control,
// front end, word queue and step engine. Uses psd_pkg, psd_front, psd_queue, psd_back.
//
//   channel  prefix  direction  carries
//   input    s_      in         five samples and counting enable, one word per tick
//   result   m_      out        filtered level, phase, lamps, totals, event, timeout
//   config   cfg_    in         register index and write data
//
// Sustained rate is one word per cycle when the result side does not stall; an accepted
// word passes the two front-end stages and the queue before it reaches the result register.
// The filter and phase update are combinational logic in the step engine.
// aresetn is synchronous, active low; it clears control state, loads register defaults.
// s_ready drops while four words are in flight between acceptance and the result register.
`timescale 1ns / 1ps
`default_nettype none

module pressure_step_detector #(
    parameter int SAMPLES_PER_TICK = 5
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [psd_pkg::SAMPLE_W-1:0]      s_sample_a,
    input  wire logic [psd_pkg::SAMPLE_W-1:0]      s_sample_b,
    input  wire logic [psd_pkg::SAMPLE_W-1:0]      s_sample_c,
    input  wire logic [psd_pkg::SAMPLE_W-1:0]      s_sample_d,
    input  wire logic [psd_pkg::SAMPLE_W-1:0]      s_sample_e,
    input  wire logic                              s_counting_enabled,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [psd_pkg::LEVEL_W-1:0]            m_filtered_pressure,
    output logic [2:0]                             m_phase,
    output logic                                   m_walk_led,
    output logic                                   m_run_led,
    output logic [31:0]                            m_walk_steps,
    output logic [31:0]                            m_run_steps,
    output logic [1:0]                             m_step_event,
    output logic                                   m_timed_out,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [psd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [psd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = psd_pkg::CREDIT_W;

    psd_pkg::cfg_t          cfg_reg;
    logic [CW-1:0]          credit_reg;
    logic [CW-1:0]          credit_next;
    logic                   accept;
    logic                   front_valid;
    psd_pkg::queue_word_t   front_word;
    logic                   queue_valid;
    psd_pkg::queue_word_t   queue_word;
    logic                   pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = (credit_reg < CW'(psd_pkg::QUEUE_DEPTH));
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.walk_threshold <= '0;
            cfg_reg.run_threshold  <= '0;
            cfg_reg.hang_threshold <= '0;
            cfg_reg.smooth_factor  <= psd_pkg::SMOOTH_FACTOR_RESET;
            cfg_reg.walk_dwell     <= psd_pkg::WALK_DWELL_RESET;
            cfg_reg.run_dwell      <= psd_pkg::RUN_DWELL_RESET;
            cfg_reg.timeout_limit  <= psd_pkg::TIMEOUT_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                psd_pkg::CFG_WALK_THRESHOLD: cfg_reg.walk_threshold <= cfg_data;
                psd_pkg::CFG_RUN_THRESHOLD:  cfg_reg.run_threshold  <= cfg_data;
                psd_pkg::CFG_HANG_THRESHOLD: cfg_reg.hang_threshold <= cfg_data;
                psd_pkg::CFG_SMOOTH_FACTOR:  cfg_reg.smooth_factor  <= cfg_data[7:0];
                psd_pkg::CFG_WALK_DWELL:     cfg_reg.walk_dwell     <= cfg_data[7:0];
                psd_pkg::CFG_RUN_DWELL:      cfg_reg.run_dwell      <= cfg_data[7:0];
                psd_pkg::CFG_TIMEOUT_LIMIT:  cfg_reg.timeout_limit  <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        credit_next = credit_reg;
        if (accept && !pop) begin
            credit_next = credit_reg + 1'b1;
        end else if (pop && !accept) begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    psd_front #(
        .SAMPLES_PER_TICK (SAMPLES_PER_TICK)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (accept),
        .sample_a         (s_sample_a),
        .sample_b         (s_sample_b),
        .sample_c         (s_sample_c),
        .sample_d         (s_sample_d),
        .sample_e         (s_sample_e),
        .counting_enabled (s_counting_enabled),
        .out_valid        (front_valid),
        .out_word         (front_word)
    );

    psd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .push_word (front_word),
        .pop       (pop),
        .out_valid (queue_valid),
        .out_word  (queue_word)
    );

    psd_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg_reg),
        .in_valid            (queue_valid),
        .in_word             (queue_word),
        .pop                 (pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_filtered_pressure (m_filtered_pressure),
        .m_phase             (m_phase),
        .m_walk_led          (m_walk_led),
        .m_run_led           (m_run_led),
        .m_walk_steps        (m_walk_steps),
        .m_run_steps         (m_run_steps),
        .m_step_event        (m_step_event),
        .m_timed_out         (m_timed_out)
    );

    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= CW'(psd_pkg::QUEUE_DEPTH))
        else $error("credit count above queue depth");

endmodule

`default_nettype wire
